// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, but also checked while reset is asserted.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hw/rtl/rgh_pkg.sv
// Package for the gray/histogram block: constants, codes and beat types.
// No dependencies; imported by rgb_gray_and_channel_histogram.
`default_nettype none

package rgh_pkg;

  localparam int MAX_ROW_PIXELS = 4096;
  localparam int BIN_COUNT      = 16;
  localparam int COUNT_BITS     = 32;
  localparam int NUM_CHANNELS   = 3;

  localparam int ROW_W   = $clog2(MAX_ROW_PIXELS + 1);
  localparam int COL_W   = $clog2(MAX_ROW_PIXELS);
  localparam int BIN_W   = $clog2(BIN_COUNT);
  localparam int CNT_W   = 32;
  localparam int BEATS_W = 3;

  // floor(x/3) == (x*683) >> 11 for x <= 765
  localparam int DIV3_MUL   = 683;
  localparam int DIV3_SHIFT = 11;

  localparam logic ACT_PIXEL = 1'b0;
  localparam logic ACT_READ  = 1'b1;

  localparam logic KIND_IMAGE = 1'b0;
  localparam logic KIND_COUNT = 1'b1;

  localparam logic [1:0] CH_BLUE  = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_RED   = 2'd2;

  typedef struct packed {
    logic       action;
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic [7:0] byte_third;
    logic [1:0] read_channel;
    logic [3:0] read_bin;
  } in_item_t;

  typedef struct packed {
    logic             kind;
    logic [7:0]       image_byte;
    logic [CNT_W-1:0] bin_count;
    logic             last;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/rgh_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the histogram bin storage.
`default_nettype none

module rgh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rgb_gray_and_channel_histogram.sv
// Top level: RGB average gray with per-channel 16-bin saturating histograms.
// Depends on rgh_pkg, rgh_ram and assert_macros.svh.
//
//   channel | ports                          | direction | beat
//   --------+--------------------------------+-----------+----------------------------
//   input   | in_valid, in_stall, in_data    | in        | pixel or bin read request
//   output  | out_valid, out_stall, out_data | out       | gray/pad byte or bin count
//   config  | cfg_valid, cfg_ready, cfg_data | in        | row width, always ready
//
// A pixel yields 3 to 6 output beats, a bin read 1; padding beats and output stalls
// keep the job buffer full longer and so hold off the next input item.
// Each pixel does one read-modify-write per channel RAM; an item is held off
// while the previous one sits in the update stage or the job buffer.
// Reset clears the 48 bin valid bits at once; no clearing pass is needed.
// A stalled output holds its beat; input is stalled once the job buffer fills.
`default_nettype none

module rgb_gray_and_channel_histogram
  import rgh_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_stall,
  input  wire in_item_t         in_data,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      out_item_t        out_data,
  input  wire logic             cfg_valid,
  output      logic             cfg_ready,
  input  wire logic [ROW_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  typedef struct packed {
    logic               kind;
    logic [7:0]         gray;
    logic [CNT_W-1:0]   count;
    logic [BEATS_W-1:0] nbeats;
  } job_t;

  logic                 in_accept;
  logic [ROW_W-1:0]     row_width_r;
  logic [ROW_W-1:0]     width_eff;
  logic [COL_W-1:0]     col_r;
  logic [COL_W-1:0]     col_nxt;
  logic                 row_end;
  logic [9:0]           px_sum;
  logic [19:0]          px_prod;
  logic [NUM_CHANNELS-1:0][7:0] px_bytes;
  logic [NUM_CHANNELS-1:0][BIN_W-1:0] rd_addr;

  logic                 s1_v_r;
  logic                 s1_action_r;
  logic [1:0]           s1_ch_r;
  logic [7:0]           s1_gray_r;
  logic [BEATS_W-1:0]   s1_nbeats_r;
  logic [NUM_CHANNELS-1:0][BIN_W-1:0] s1_addr_r;
  logic [NUM_CHANNELS-1:0] s1_ok_r;

  logic [NUM_CHANNELS-1:0][BIN_COUNT-1:0] valid_r;
  logic [NUM_CHANNELS-1:0][COUNT_BITS-1:0] ram_q;
  logic [NUM_CHANNELS-1:0][COUNT_BITS-1:0] cnt_cur;
  logic [NUM_CHANNELS-1:0][COUNT_BITS-1:0] cnt_inc;
  logic                 bin_we;
  logic [COUNT_BITS-1:0] count_sel;

  logic                 jb_v_r;
  job_t                 jb_r;
  logic                 cur_v_r;
  job_t                 cur_r;
  logic [BEATS_W-1:0]   beat_r;
  logic                 beat_last;
  logic                 out_load;
  logic                 jb_take;
  logic                 out_valid_r;
  out_item_t            out_data_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = s1_v_r || jb_v_r;
  assign in_accept = in_valid && !in_stall;

  // row geometry
  always_comb begin
    if (row_width_r == '0) begin
      width_eff = ROW_W'(1);
    end else if (row_width_r > ROW_W'(MAX_ROW_PIXELS)) begin
      width_eff = ROW_W'(MAX_ROW_PIXELS);
    end else begin
      width_eff = row_width_r;
    end
  end

  assign row_end = ({1'b0, col_r} + ROW_W'(1)) >= width_eff;
  assign col_nxt = row_end ? '0 : col_r + COL_W'(1);

  assign px_sum  = 10'(in_data.byte_first) + 10'(in_data.byte_second)
                 + 10'(in_data.byte_third);
  assign px_prod = 20'(px_sum) * 20'(DIV3_MUL);

  assign px_bytes = {in_data.byte_third, in_data.byte_second, in_data.byte_first};

  // histogram storage, one RAM per channel
  assign bin_we = s1_v_r && (s1_action_r == ACT_PIXEL);

  for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_ch
    assign rd_addr[c] = (in_data.action == ACT_READ) ? in_data.read_bin
                                                     : px_bytes[c][7:4];
    assign cnt_cur[c] = s1_ok_r[c] ? ram_q[c] : '0;
    assign cnt_inc[c] = (cnt_cur[c] == '1) ? cnt_cur[c] : cnt_cur[c] + COUNT_BITS'(1);

    rgh_ram #(
      .WIDTH (COUNT_BITS),
      .DEPTH (BIN_COUNT)
    ) u_bins (
      .clk   (clk),
      .we    (bin_we),
      .waddr (s1_addr_r[c]),
      .wdata (cnt_inc[c]),
      .re    (in_accept),
      .raddr (rd_addr[c]),
      .rdata (ram_q[c])
    );
  end

  always_comb begin
    case (s1_ch_r)
      CH_BLUE:  count_sel = cnt_cur[0];
      CH_GREEN: count_sel = cnt_cur[1];
      CH_RED:   count_sel = cnt_cur[2];
      default:  count_sel = '0;
    endcase
  end

  // config, column and update stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= ROW_W'(1);
      col_r       <= '0;
      s1_v_r      <= 1'b0;
      valid_r     <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        row_width_r <= cfg_data;
      end
      s1_v_r <= in_accept;
      if (in_accept && (in_data.action == ACT_PIXEL)) begin
        col_r <= col_nxt;
      end
      if (bin_we) begin
        for (int c = 0; c < NUM_CHANNELS; c++) begin
          valid_r[c][s1_addr_r[c]] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_action_r <= in_data.action;
      s1_ch_r     <= in_data.read_channel;
      s1_gray_r   <= px_prod[DIV3_SHIFT +: 8];
      s1_addr_r   <= rd_addr;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        s1_ok_r[c] <= valid_r[c][rd_addr[c]];
      end
      if (in_data.action == ACT_READ) begin
        s1_nbeats_r <= BEATS_W'(1);
      end else if (row_end) begin
        s1_nbeats_r <= BEATS_W'(3) + BEATS_W'(width_eff[1:0]);
      end else begin
        s1_nbeats_r <= BEATS_W'(3);
      end
    end
  end

  // job buffer and beat emitter
  assign beat_last = (beat_r == cur_r.nbeats - BEATS_W'(1));
  assign out_load  = cur_v_r && (!out_valid_r || !out_stall);
  assign jb_take   = !cur_v_r || (out_load && beat_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      jb_v_r      <= 1'b0;
      cur_v_r     <= 1'b0;
      beat_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_v_r) begin
        jb_v_r <= 1'b1;
        jb_r   <= '{kind:   (s1_action_r == ACT_READ) ? KIND_COUNT : KIND_IMAGE,
                    gray:   s1_gray_r,
                    count:  CNT_W'(count_sel),
                    nbeats: s1_nbeats_r};
      end else if (jb_take) begin
        jb_v_r <= 1'b0;
      end

      if (jb_take) begin
        cur_v_r <= jb_v_r;
        cur_r   <= jb_r;
        beat_r  <= '0;
      end else if (out_load) begin
        beat_r <= beat_r + BEATS_W'(1);
      end

      if (out_load) begin
        out_valid_r <= 1'b1;
        out_data_r  <= '{kind:       cur_r.kind,
                         image_byte: ((cur_r.kind == KIND_IMAGE) && (beat_r < BEATS_W'(3)))
                                     ? cur_r.gray : 8'd0,
                         bin_count:  (cur_r.kind == KIND_COUNT) ? cur_r.count : '0,
                         last:       beat_last};
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `ASSERT_CLK(a_jb_free, clk, rst_n, s1_v_r |-> !jb_v_r, "update stage found job buffer full")
  `ASSERT_CLK(a_beat_range, clk, rst_n, cur_v_r |-> (beat_r < cur_r.nbeats), "beat index past job end")
  `ASSERT_CLK(a_count_last, clk, rst_n, (out_valid && (out_data.kind == KIND_COUNT)) |-> out_data.last, "count beat without last")

endmodule

`default_nettype wire

// File: tb/sv/rgb_gray_and_channel_histogram_tb.sv
// Testbench for rgb_gray_and_channel_histogram: directed table, then random pixels and bin reads.
// Output beats are checked against an in-bench gray/histogram predictor. Depends on rgh_pkg.
module rgb_gray_and_channel_histogram_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rgh_pkg::*;

  localparam logic [1:0] CH_UNUSED = 2'd3;
  localparam int NUM_BINS = NUM_CHANNELS * BIN_COUNT;
  localparam int MAX_REPORTS = 10;
  localparam int QUIET_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 16;
  localparam int NUM_PHASES = 4;
  localparam int CHUNKS_PER_PHASE = 3;
  localparam int ITEMS_PER_CHUNK = 30;
  localparam int SCRIPT_LEN = 26;

  typedef enum logic {ROW_BEAT, ROW_WIDTH} row_op_t;

  typedef struct {
    row_op_t          op;
    logic             act;
    logic [7:0]       b;
    logic [7:0]       g;
    logic [7:0]       r;
    logic [1:0]       ch;
    logic [3:0]       bin;
    logic [ROW_W-1:0] width;
    bit               fixed;
    logic [CNT_W-1:0] val;
  } row_t;

  logic             clk;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  in_item_t         in_data;
  logic             out_valid;
  logic             out_stall;
  out_item_t        out_data;
  logic             cfg_valid;
  logic             cfg_ready;
  logic [ROW_W-1:0] cfg_data;

  logic [CNT_W-1:0] hist [NUM_BINS];
  logic [COL_W-1:0] column;
  logic [ROW_W-1:0] width_reg;
  out_item_t        due_beats [$];
  out_item_t        want_beat;
  int               errors;
  int               gap_pct;
  int               stall_pct;
  int               quiet_cycles;

  int phase_gap   [NUM_PHASES] = '{0, 56, 0, 22};
  int phase_stall [NUM_PHASES] = '{0, 0, 56, 22};

  // typed val: count for reads, gray byte for pixels
  row_t script [SCRIPT_LEN] = '{
    '{ROW_BEAT,  ACT_READ,  8'h00, 8'h00, 8'h00, CH_BLUE,   4'd0,  13'd0,    1'b1, 32'd0},
    '{ROW_BEAT,  ACT_READ,  8'h00, 8'h00, 8'h00, CH_UNUSED, 4'd15, 13'd0,    1'b1, 32'd0},
    '{ROW_BEAT,  ACT_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,   4'd0,  13'd0,    1'b1, 32'd0},
    '{ROW_BEAT,  ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF, CH_UNUSED, 4'd15, 13'd0,    1'b1, 32'd255},
    '{ROW_BEAT,  ACT_PIXEL, 8'hFF, 8'h00, 8'h00, CH_RED,    4'd5,  13'd0,    1'b1, 32'd85},
    '{ROW_BEAT,  ACT_PIXEL, 8'h01, 8'h01, 8'h00, CH_GREEN,  4'd10, 13'd0,    1'b1, 32'd0},
    '{ROW_BEAT,  ACT_READ,  8'h00, 8'h00, 8'h00, CH_RED,    4'd15, 13'd0,    1'b0, 32'd0},
    '{ROW_BEAT,  ACT_READ,  8'hFF, 8'hFF, 8'hFF, CH_BLUE,   4'd15, 13'd0,    1'b0, 32'd0},
    '{ROW_WIDTH, ACT_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,   4'd0,  13'd0,    1'b0, 32'd0},
    '{ROW_BEAT,  ACT_PIXEL, 8'h55, 8'hAA, 8'h0F, CH_UNUSED, 4'd15, 13'd0,    1'b0, 32'd0},
    '{ROW_WIDTH, ACT_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,   4'd0,  13'd3,    1'b0, 32'd0},
    '{ROW_BEAT,  ACT_PIXEL, 8'h10, 8'h20, 8'h30, CH_BLUE,   4'd0,  13'd0,    1'b0, 32'd0},
    '{ROW_BEAT,  ACT_PIXEL, 8'h80, 8'h7F, 8'hFE, CH_GREEN,  4'd7,  13'd0,    1'b0, 32'd0},
    '{ROW_BEAT,  ACT_PIXEL, 8'h0F, 8'hF0, 8'h99, CH_RED,    4'd8,  13'd0,    1'b0, 32'd0},
    '{ROW_WIDTH, ACT_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,   4'd0,  13'd8191, 1'b0, 32'd0},
    '{ROW_BEAT,  ACT_PIXEL, 8'h11, 8'h22, 8'h33, CH_BLUE,   4'd0,  13'd0,    1'b0, 32'd0},
    '{ROW_BEAT,  ACT_PIXEL, 8'h44, 8'h55, 8'h66, CH_BLUE,   4'd0,  13'd0,    1'b0, 32'd0},
    '{ROW_WIDTH, ACT_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,   4'd0,  13'd4096, 1'b0, 32'd0},
    '{ROW_BEAT,  ACT_PIXEL, 8'hC0, 8'h3C, 8'h03, CH_BLUE,   4'd0,  13'd0,    1'b0, 32'd0},
    '{ROW_WIDTH, ACT_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,   4'd0,  13'd2,    1'b0, 32'd0},
    '{ROW_BEAT,  ACT_PIXEL, 8'hAB, 8'hCD, 8'hEF, CH_BLUE,   4'd0,  13'd0,    1'b0, 32'd0},
    '{ROW_BEAT,  ACT_PIXEL, 8'h7E, 8'h81, 8'h42, CH_BLUE,   4'd0,  13'd0,    1'b0, 32'd0},
    '{ROW_BEAT,  ACT_READ,  8'h00, 8'h00, 8'h00, CH_GREEN,  4'd10, 13'd0,    1'b0, 32'd0},
    '{ROW_BEAT,  ACT_READ,  8'h00, 8'h00, 8'h00, CH_UNUSED, 4'd0,  13'd0,    1'b1, 32'd0},
    '{ROW_WIDTH, ACT_PIXEL, 8'h00, 8'h00, 8'h00, CH_BLUE,   4'd0,  13'd5,    1'b0, 32'd0},
    '{ROW_BEAT,  ACT_PIXEL, 8'hFE, 8'h01, 8'h7F, CH_BLUE,   4'd0,  13'd0,    1'b0, 32'd0}
  };

  rgb_gray_and_channel_histogram uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic void predict_gray_and_bins(input in_item_t it, input bit fixed,
                                                input logic [CNT_W-1:0] fixed_val);
    int unsigned w;
    int unsigned pad;
    int unsigned gray;
    int unsigned idx;
    logic [7:0] chan [NUM_CHANNELS];
    out_item_t beat;
    if (it.action == ACT_READ) begin
      beat = '{kind: KIND_COUNT, image_byte: 8'd0, bin_count: '0, last: 1'b1};
      if (it.read_channel != CH_UNUSED)
        beat.bin_count = hist[it.read_channel * BIN_COUNT + it.read_bin];
      if (fixed)
        beat.bin_count = fixed_val;
      due_beats.push_back(beat);
    end else begin
      w = width_reg;
      if (w == 0)
        w = 1;
      if (w > MAX_ROW_PIXELS)
        w = MAX_ROW_PIXELS;
      chan[0] = it.byte_first;
      chan[1] = it.byte_second;
      chan[2] = it.byte_third;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        idx = c * BIN_COUNT + chan[c][7:4];
        if (hist[idx] != '1)
          hist[idx] = hist[idx] + 1'b1;
      end
      if (column + 1 >= w) begin
        pad = w % 4;
        column = '0;
      end else begin
        pad = 0;
        column = column + 1'b1;
      end
      gray = (it.byte_first + it.byte_second + it.byte_third) / 3;
      for (int i = 0; i < 3; i++) begin
        beat = '{kind: KIND_IMAGE, image_byte: gray[7:0], bin_count: '0,
                 last: (pad == 0 && i == 2)};
        if (fixed)
          beat.image_byte = fixed_val[7:0];
        due_beats.push_back(beat);
      end
      for (int i = 0; i < pad; i++)
        due_beats.push_back('{kind: KIND_IMAGE, image_byte: 8'd0, bin_count: '0,
                              last: (i + 1 == pad)});
    end
  endfunction

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_beats.size() != 0);
  endtask

  task automatic send_beat(input in_item_t it, input bit fixed, input logic [CNT_W-1:0] fixed_val);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
    predict_gray_and_bins(it, fixed, fixed_val);
  endtask

  task automatic write_width(input logic [ROW_W-1:0] w);
    drain();
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_reg = w;
  endtask

  always @(posedge clk)
    out_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (due_beats.size() == 0) begin
        if (errors < MAX_REPORTS)
          $display("unexpected beat: kind %0d byte %0d count %0d last %0d",
                   out_data.kind, out_data.image_byte, out_data.bin_count, out_data.last);
        errors++;
      end else begin
        want_beat = due_beats.pop_front();
        if (out_data.kind !== want_beat.kind || out_data.image_byte !== want_beat.image_byte ||
            out_data.bin_count !== want_beat.bin_count || out_data.last !== want_beat.last) begin
          if (errors < MAX_REPORTS)
            $display("mismatch: exp kind %0d byte %0d count %0d last %0d, got %0d %0d %0d %0d",
                     want_beat.kind, want_beat.image_byte, want_beat.bin_count, want_beat.last,
                     out_data.kind, out_data.image_byte, out_data.bin_count, out_data.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
      $display("FAIL rgb_gray_and_channel_histogram");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    in_item_t it;
    logic [ROW_W-1:0] w;
    int k;
    errors = 0;
    gap_pct = 0;
    stall_pct = 0;
    column = '0;
    width_reg = 1;
    foreach (hist[i])
      hist[i] = '0;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].op == ROW_WIDTH)
        write_width(script[i].width);
      else begin
        it.action = script[i].act;
        it.byte_first = script[i].b;
        it.byte_second = script[i].g;
        it.byte_third = script[i].r;
        it.read_channel = script[i].ch;
        it.read_bin = script[i].bin;
        send_beat(it, script[i].fixed, script[i].val);
      end
    end

    for (int p = 0; p < NUM_PHASES; p++) begin
      gap_pct = phase_gap[p];
      stall_pct = phase_stall[p];
      for (int c = 0; c < CHUNKS_PER_PHASE; c++) begin
        k = p * CHUNKS_PER_PHASE + c;
        if (k == 3)
          w = 13'd4096;
        else if (k == 6)
          w = 13'd0;
        else if (k == 9)
          w = 13'($urandom_range(8191, 4097));
        else if (k == 11)
          w = 13'($urandom_range(40, 9));
        else
          w = 13'($urandom_range(8, 1));
        write_width(w);
        repeat (ITEMS_PER_CHUNK) begin
          it.action = ($urandom_range(99) < 18) ? ACT_READ : ACT_PIXEL;
          it.byte_first = rand_byte();
          it.byte_second = rand_byte();
          it.byte_third = rand_byte();
          it.read_channel = 2'($urandom_range(3));
          it.read_bin = 4'($urandom_range(15));
          send_beat(it, 1'b0, '0);
        end
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (due_beats.size() != 0) begin
      $display("%0d expected beats never arrived", due_beats.size());
      errors++;
    end
    if (errors == 0)
      $display("PASS rgb_gray_and_channel_histogram");
    else
      $display("FAIL rgb_gray_and_channel_histogram");
    $finish;
  end

endmodule
